// ===== rtl/core/swam_pkg.sv =====
// Package for the sliding window anagram matcher.
// Holds sizes, item kind codes and the symbol clamp; no dependencies.
package swam_pkg;

    localparam int MAX_PATTERN  = 256;
    localparam int SYMBOL_COUNT = 256;

    localparam int KIND_W  = 2;
    localparam int SYMIN_W = 8;
    localparam int SYM_W   = $clog2(SYMBOL_COUNT);
    localparam int PTR_W   = $clog2(MAX_PATTERN);
    localparam int CNT_W   = $clog2(MAX_PATTERN + 1);
    localparam int DIFF_W  = CNT_W + 1;
    localparam int MIS_W   = $clog2(SYMBOL_COUNT + 1);

    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PATTERN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd2;

    typedef logic [SYM_W-1:0] t_sym;

    // Saturate a byte to the last symbol of the alphabet.
    function automatic t_sym clamp_symbol(input logic [SYMIN_W-1:0] s);
        int v;
        v = int'(s);
        if (v >= SYMBOL_COUNT) begin
            return SYM_W'(SYMBOL_COUNT - 1);
        end
        return SYM_W'(v);
    endfunction

endpackage

// ===== rtl/core/sliding_window_anagram_match.sv =====
// Sliding window anagram matcher: difference histogram, window delay line,
// one shared +/-1 read-modify-write unit under a small sequencer. Uses swam_pkg.
//
//  channel | ports                                         | dir
//  --------+-----------------------------------------------+-----
//  in      | i_in_valid o_in_ready i_kind i_symbol         | in
//  out     | o_out_valid i_out_ready o_match_here o_found  | out
//          | o_pattern_overflow                            |
//
// Steps per item, from the accept until the result is loaded: clear, dropped
// pattern byte, text with empty pattern and unused kind go to the result;
// pattern byte or text byte while the window fills: one adjustment; text byte
// with eviction: window read, then two adjustments. On the single-port
// histogram memory each adjustment is a read step then a modify-write step.
// Reset (i_rst_n low, synchronous) empties the search like a clear item.
// A full result register holds the sequencer in its last state until taken.
module sliding_window_anagram_match (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [swam_pkg::KIND_W-1:0]  i_kind,
    input  logic [swam_pkg::SYMIN_W-1:0] i_symbol,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_match_here,
    output logic                         o_found,
    output logic                         o_pattern_overflow
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WRD  = 3'd1;
    localparam logic [2:0] ST_DRD  = 3'd2;
    localparam logic [2:0] ST_ADJ  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam int PW = swam_pkg::PTR_W;
    localparam int CW = swam_pkg::CNT_W;
    localparam int DW = swam_pkg::DIFF_W;
    localparam int MW = swam_pkg::MIS_W;

    logic [2:0]                  r_state, n_state;
    logic [swam_pkg::KIND_W-1:0] r_kind, n_kind;
    swam_pkg::t_sym              r_sym, n_sym;
    swam_pkg::t_sym              r_addr, n_addr;
    logic                        r_inc, n_inc;
    logic                        r_second, n_second;
    logic                        r_ovf, n_ovf;
    logic [CW-1:0]               r_pc, n_pc;
    logic [CW-1:0]               r_fill, n_fill;
    logic [PW-1:0]               r_wptr, n_wptr;
    logic [MW-1:0]               r_mis, n_mis;
    logic                        r_found, n_found;
    logic [swam_pkg::SYMBOL_COUNT-1:0] r_vld, n_vld;

    logic                        r_out_valid, n_out_valid;
    logic                        r_out_match, n_out_match;
    logic                        r_out_found, n_out_found;
    logic                        r_out_ovf, n_out_ovf;

    // histogram memory and window delay line
    logic [DW-1:0]               r_diff_mem [swam_pkg::SYMBOL_COUNT];
    logic [DW-1:0]               r_diff_q;
    logic                        r_diff_q_vld;
    logic [7:0]                  r_win_mem [swam_pkg::MAX_PATTERN];
    logic [7:0]                  r_win_q;

    logic                        diff_we;
    logic [DW-1:0]               diff_wdata;
    logic                        win_we;
    logic [PW-1:0]               win_waddr;
    logic [7:0]                  win_wdata;
    logic                        win_re;
    logic [PW-1:0]               oldest;
    logic [CW:0]                 wptr_ext;
    logic [CW:0]                 oldest_ext;
    logic [DW-1:0]               old_val;
    logic [DW-1:0]               new_val;
    logic                        accept;
    logic                        out_free;
    logic                        match_now;
    logic [PW-1:0]               wptr_inc;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign match_now = (r_mis == '0);

    assign wptr_ext   = {{(CW + 1 - PW){1'b0}}, r_wptr};
    assign oldest_ext = (wptr_ext >= {1'b0, r_fill})
                        ? (wptr_ext - {1'b0, r_fill})
                        : (wptr_ext + (CW + 1)'(swam_pkg::MAX_PATTERN) - {1'b0, r_fill});
    assign oldest     = oldest_ext[PW-1:0];
    assign wptr_inc   = (r_wptr == PW'(swam_pkg::MAX_PATTERN - 1)) ? '0 : r_wptr + 1'b1;

    assign old_val = r_diff_q_vld ? r_diff_q : '0;
    assign new_val = r_inc ? old_val + 1'b1 : old_val - 1'b1;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_sym       = r_sym;
        n_addr      = r_addr;
        n_inc       = r_inc;
        n_second    = r_second;
        n_ovf       = r_ovf;
        n_pc        = r_pc;
        n_fill      = r_fill;
        n_wptr      = r_wptr;
        n_mis       = r_mis;
        n_found     = r_found;
        n_vld       = r_vld;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_match = r_out_match;
        n_out_found = r_out_found;
        n_out_ovf   = r_out_ovf;
        diff_we     = 1'b0;
        diff_wdata  = new_val;
        win_we      = 1'b0;
        win_waddr   = r_wptr;
        win_wdata   = 8'(r_sym);
        win_re      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_kind  = i_kind;
                    n_sym   = swam_pkg::clamp_symbol(i_symbol);
                    n_ovf   = 1'b0;
                    n_state = ST_OUT;
                    case (i_kind)
                        swam_pkg::KIND_CLEAR: begin
                            n_vld   = '0;
                            n_mis   = '0;
                            n_pc    = '0;
                            n_fill  = '0;
                            n_wptr  = '0;
                            n_found = 1'b0;
                        end
                        swam_pkg::KIND_PATTERN: begin
                            if (r_pc == CW'(swam_pkg::MAX_PATTERN)) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_pc     = r_pc + 1'b1;
                                n_addr   = swam_pkg::clamp_symbol(i_symbol);
                                n_inc    = 1'b1;
                                n_second = 1'b0;
                                n_state  = ST_DRD;
                            end
                        end
                        swam_pkg::KIND_TEXT: begin
                            if (r_pc != '0) begin
                                if (r_fill >= r_pc) begin
                                    // fetch the oldest byte; new byte goes in after
                                    win_re  = 1'b1;
                                    n_state = ST_WRD;
                                end else begin
                                    win_we    = 1'b1;
                                    win_wdata = 8'(swam_pkg::clamp_symbol(i_symbol));
                                    n_wptr    = wptr_inc;
                                    n_fill    = r_fill + 1'b1;
                                    n_addr    = swam_pkg::clamp_symbol(i_symbol);
                                    n_inc     = 1'b0;
                                    n_second  = 1'b0;
                                    n_state   = ST_DRD;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WRD: begin
                // window count stays: one byte leaves, one enters
                win_we   = 1'b1;
                n_wptr   = wptr_inc;
                n_addr   = swam_pkg::clamp_symbol(r_win_q);
                n_inc    = 1'b1;
                n_second = 1'b1;
                n_state  = ST_DRD;
            end
            ST_DRD: begin
                n_state = ST_ADJ;
            end
            ST_ADJ: begin
                diff_we = 1'b1;
                n_vld[r_addr] = 1'b1;
                if (old_val != '0 && new_val == '0) begin
                    n_mis = r_mis - 1'b1;
                end else if (old_val == '0 && new_val != '0) begin
                    n_mis = r_mis + 1'b1;
                end
                if (r_second) begin
                    n_addr   = r_sym;
                    n_inc    = 1'b0;
                    n_second = 1'b0;
                    n_state  = ST_DRD;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the result register is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_match = match_now;
                    n_out_ovf   = r_ovf;
                    if (match_now && (r_kind == swam_pkg::KIND_PATTERN ||
                                      r_kind == swam_pkg::KIND_TEXT)) begin
                        n_found = 1'b1;
                    end
                    n_out_found = n_found;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_fill      <= '0;
            r_wptr      <= '0;
            r_mis       <= '0;
            r_found     <= 1'b0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
            r_ovf       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_fill      <= n_fill;
            r_wptr      <= n_wptr;
            r_mis       <= n_mis;
            r_found     <= n_found;
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
            r_second    <= n_second;
            r_ovf       <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_sym       <= n_sym;
        r_addr      <= n_addr;
        r_inc       <= n_inc;
        r_out_match <= n_out_match;
        r_out_found <= n_out_found;
        r_out_ovf   <= n_out_ovf;
    end

    // histogram: read issued in ST_DRD, written back in ST_ADJ
    always_ff @(posedge i_clk) begin
        if (diff_we) begin
            r_diff_mem[r_addr] <= diff_wdata;
        end
        if (r_state == ST_DRD) begin
            r_diff_q     <= r_diff_mem[r_addr];
            r_diff_q_vld <= r_vld[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (win_we) begin
            r_win_mem[win_waddr] <= win_wdata;
        end
        if (win_re) begin
            r_win_q <= r_win_mem[oldest];
        end
    end

    assign o_in_ready         = (r_state == ST_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_match_here       = r_out_match;
    assign o_found            = r_out_found;
    assign o_pattern_overflow = r_out_ovf;

    // the window never holds more bytes than the pattern
    a_fill_le_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_pc)
        else $error("window fill exceeds pattern count");

    // every nonzero difference needs a pattern or window byte behind it
    a_mis_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_mis} <= ({1'b0, r_pc} + {1'b0, r_fill}))
        else $error("mismatch count exceeds bytes held");

    // an adjustment is followed by another read or by the result
    a_adj_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADJ) |=> (r_state == ST_DRD || r_state == ST_OUT))
        else $error("sequencer left adjust step wrongly");

endmodule
